/* design/f2h_pkg.sv */
`timescale 1ns / 1ps
package f2h_pkg;
	typedef enum logic {
		CMD_NARROW = 1'b0,
		CMD_WIDEN  = 1'b1
	} cmd_t;

	localparam logic [14:0] H_INF    = 15'h7c00;
	localparam int          F_BIAS   = 127;
	localparam int          H_BIAS   = 15;
	localparam logic [12:0] HALF_LSB = 13'h1000;
	localparam logic [7:0]  F_EMAX   = 8'hff;
	localparam logic [4:0]  H_EMAX   = 5'h1f;
	localparam int          SUB_BASE = 14;

	typedef struct packed {
		logic        cmd;
		logic [31:0] operand;
	} item_t;
endpackage

/* design/fp32_fp16_converter_core.sv */
`timescale 1ns / 1ps
// The start transfer reaches the done strobe through the input and result registers.
// Throughput: one item per cycle; busy is tied low, the input and result
// registers form a two-stage pipeline with short logic between them.
// Reset: arst_n clears the valid flags asynchronously; payload registers hold.
// The receiver cannot stall; each result shows for one cycle with done.
module fp32_fp16_converter_core import f2h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] operand,
	output logic        done,
	output logic [31:0] converted
);
	item_t       in_s1;
	logic        vld_s1;
	logic [15:0] half_w;
	logic [31:0] word_w;
	logic [31:0] res_s2;
	logic        vld_s2;

	assign busy = 1'b0;

	// Capture each transfer; drop the valid flag when idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			in_s1.cmd     <= cmd;
			in_s1.operand <= operand;
		end
		res_s2 <= (cmd_t'(in_s1.cmd) == CMD_WIDEN) ? word_w : {16'd0, half_w};
	end

	f2h_narrow u_narrow (.raw(in_s1.operand), .half(half_w));
	f2h_widen  u_widen  (.half(in_s1.operand[15:0]), .word(word_w));

	assign done      = vld_s2;
	assign converted = res_s2;

`ifndef ASSERT_OFF
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done) else $error("result missing");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 2) |-> !done) else $error("spurious result");
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(in_s1.cmd) == CMD_NARROW |-> converted[31:16] == 16'd0)
		else $error("upper half not zero");
`endif
endmodule

/* design/f2h_narrow.sv */
`timescale 1ns / 1ps
module f2h_narrow import f2h_pkg::*; (
	input  logic [31:0] raw,
	output logic [15:0] half
);
	logic        sign;
	logic [7:0]  fexp;
	logic [22:0] frac;
	logic [9:0]  pay;
	logic signed [9:0] hexp;
	logic [4:0]  sh;
	logic [23:0] mant;
	logic [23:0] kept;
	logic [23:0] rem;
	logic [23:0] hlf;
	logic [10:0] sub;
	logic [12:0] drop;
	logic        up;
	logic [15:0] norm;

	always_comb begin
		sign = raw[31];
		fexp = raw[30:23];
		frac = raw[22:0];
		pay  = frac[22:13];
		hexp = 10'(signed'({2'b00, fexp})) - 10'(F_BIAS - H_BIAS);
		mant = {1'b1, frac};
		sh   = 5'(10'(SUB_BASE) - hexp);
		kept = mant >> sh;
		rem  = mant & ((24'd1 << sh) - 24'd1);
		hlf  = 24'd1 << (sh - 5'd1);
		sub  = 11'(kept) + 11'((rem > hlf || (rem == hlf && kept[0])) ? 1 : 0);
		drop = frac[12:0];
		up   = drop > HALF_LSB || (drop == HALF_LSB && frac[13]);
		// carry from fraction rolls into exponent naturally
		norm = {1'b0, hexp[4:0], pay} + 16'(up);
		if (fexp == F_EMAX) begin
			half = {sign, H_INF | ((frac == 23'd0) ? 15'd0 :
				(pay == 10'd0 ? 15'd1 : {5'd0, pay}))};
		end else if (hexp >= 10'sd31) begin
			half = {sign, H_INF};
		end else if (hexp <= 10'sd0) begin
			half = (hexp < -10'sd10) ? {sign, 15'd0} : {sign, 4'd0, sub};
		end else if (norm[14:10] == H_EMAX) begin
			half = {sign, H_INF};
		end else begin
			half = {sign, norm[14:0]};
		end
	end
endmodule

/* design/f2h_widen.sv */
`timescale 1ns / 1ps
module f2h_widen import f2h_pkg::*; (
	input  logic [15:0] half,
	output logic [31:0] word
);
	logic [4:0] hexp;
	logic [9:0] frac;
	logic [3:0] lz;
	logic [9:0] nf;

	always_comb begin
		hexp = half[14:10];
		frac = half[9:0];
		lz = 4'd0;
		// priority encode leading one
		for (int i = 0; i < 10; i++) begin
			if (frac[i]) lz = 4'(9 - i);
		end
		nf = 10'(frac << (lz + 4'd1));
		if (hexp == 5'd0) begin
			if (frac == 10'd0) word = {half[15], 31'd0};
			else word = {half[15], 8'(F_BIAS - SUB_BASE - 1) - 8'(lz), nf, 13'd0};
		end else if (hexp == H_EMAX) begin
			word = {half[15], F_EMAX, frac, 13'd0};
		end else begin
			word = {half[15], 8'(hexp) + 8'(F_BIAS - H_BIAS), frac, 13'd0};
		end
	end
endmodule
